// ===== rtl/core/rc4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 shared definitions
// Constants, register indexes and the command/status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W          = 8;
    localparam int SBOX_DEPTH      = 256;
    localparam int SBOX_ADDR_W     = 8;
    localparam int KEY_REG_W       = 64;
    localparam int KEY_LEN_W       = 5;
    localparam int KEY_TOTAL_BYTES = 16;
    localparam int KEY_SEL_W       = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;

    // Operation codes carried on the input tuser bit.
    localparam logic OP_REKEY = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

    // Commands issued by the controller.
    typedef struct packed {
        logic accept_key;   // rekey transaction taken: clear S-box, j, k and key position
        logic accept_data;  // data transaction taken: advance i, latch byte
        logic key_mode;     // current pass is key scheduling
        logic rd_a;         // read S[k] or S[i]
        logic rd_b;         // update j, read S[j]
        logic wr_a;         // write S[k] or S[i] with old S[j]
        logic wr_b;         // write S[j] with old S[k] or S[i]
        logic rd_t;         // read keystream entry
        logic load_out;     // load the result register
    } cmd_t;

    typedef struct packed {
        logic last_step;    // key scheduling step counter at its final entry
        logic out_free;     // result register can take a new byte
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/rc4_stream_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher, byte wide
// Key scheduling on a rekey transaction, keystream XOR on a data transaction.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                        Carries
//  -------  ---------  -----------------------------  -------------------------
//  s_       in         s_tvalid s_tready s_tdata      data_byte; tuser = opcode
//                      s_tuser
//  m_       out        m_tvalid m_tready m_tdata      out_byte
//  cfg_     in         cfg_wr_en cfg_addr cfg_data    key_length/key_low/high
//
// A data transaction makes one S-box access per step through the S-box RAM
// (read S[i], read S[j], two swap writes, keystream read), then a result
// load; the next one is accepted only after the load.
// A rekey transaction runs 256 key scheduling steps of four RAM accesses each.
// Reset and every rekey clear the S-box through a valid bit per entry, so no
// clearing pass is needed.
// A result waiting on m_tready stalls only the final load step; the input
// side accepts the next transaction as soon as the previous one is loaded.
//
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input channel.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rc4_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  wire logic                            s_tuser,   // [0] opcode
    // Result channel.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [rc4_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
    // Configuration write port.
    input  wire logic                            cfg_wr_en,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rc4_pkg::*;

    logic [KEY_LEN_W-1:0] key_length_reg;
    logic [KEY_REG_W-1:0] key_low_reg;
    logic [KEY_REG_W-1:0] key_high_reg;
    cmd_t                 cmd;
    sts_t                 sts;

    // Configuration registers. Writes to an unused index are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= KEY_LEN_RESET;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                REG_KEY_LOW:    key_low_reg    <= cfg_data[KEY_REG_W-1:0];
                REG_KEY_HIGH:   key_high_reg   <= cfg_data[KEY_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // The controller steps through the RAM accesses of each transaction.
    rc4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the S-box, the indices and the result register.
    rc4_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .data_byte  (s_tdata),
        .key_length (key_length_reg),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

    // The result register is loaded only when its previous byte is gone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before it was taken");

    // Only one transaction is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a transaction is in work");

    // A new result appears only after a load command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

    // Key scheduling never produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.key_mode |-> !cmd.load_out)
    else $error("result loaded during key scheduling");

endmodule
`default_nettype wire

// ===== rtl/core/rc4_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 generic RAM
// One write port, one read port with registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rc4_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences the S-box read/swap steps for key scheduling and data bytes.
// ----------------------------------------------------------------------------
module rc4_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          opcode,
    input  wire rc4_pkg::sts_t sts,
    output rc4_pkg::cmd_t      cmd
);
    import rc4_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WR_A,
        ST_WR_B,
        ST_RD_T,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   key_mode_reg;
    logic   take;

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            key_mode_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        key_mode_reg <= (opcode == OP_REKEY);
                        state_reg    <= ST_RD_A;
                    end
                end
                ST_RD_A: state_reg <= ST_RD_B;
                ST_RD_B: state_reg <= ST_WR_A;
                ST_WR_A: state_reg <= ST_WR_B;
                ST_WR_B: begin
                    if (!key_mode_reg) begin
                        state_reg <= ST_RD_T;
                    end else if (sts.last_step) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_RD_A;
                    end
                end
                ST_RD_T: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (sts.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd             = '0;
        cmd.accept_key  = take && (opcode == OP_REKEY);
        cmd.accept_data = take && (opcode == OP_DATA);
        cmd.key_mode    = key_mode_reg;
        cmd.rd_a        = (state_reg == ST_RD_A);
        cmd.rd_b        = (state_reg == ST_RD_B);
        cmd.wr_a        = (state_reg == ST_WR_A);
        cmd.wr_b        = (state_reg == ST_WR_B);
        cmd.rd_t        = (state_reg == ST_RD_T);
        cmd.load_out    = (state_reg == ST_OUT) && sts.out_free;
    end

endmodule
`default_nettype wire

// ===== rtl/core/rc4_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 datapath
// S-box RAM with per-entry valid bits, the i/j/k indices, key byte selection
// and the result register.
// ----------------------------------------------------------------------------
module rc4_datapath #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire rc4_pkg::cmd_t                  cmd,
    output rc4_pkg::sts_t                       sts,
    input  wire logic [rc4_pkg::BYTE_W-1:0]     data_byte,
    input  wire logic [rc4_pkg::KEY_LEN_W-1:0]  key_length,
    input  wire logic [rc4_pkg::KEY_REG_W-1:0]  key_low,
    input  wire logic [rc4_pkg::KEY_REG_W-1:0]  key_high,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic      [rc4_pkg::BYTE_W-1:0]     m_tdata
);
    import rc4_pkg::*;

    localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

    logic [SBOX_ADDR_W-1:0] i_reg, j_reg, k_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [BYTE_W-1:0]      si_reg, sj_reg, data_reg;
    logic                   rd_valid_reg;
    logic [SBOX_ADDR_W-1:0] rd_addr_reg;
    logic [SBOX_DEPTH-1:0]  valid_reg;
    logic                   m_tvalid_reg;
    logic [BYTE_W-1:0]      m_tdata_reg;

    logic [KEY_LEN_W-1:0]   len_eff;
    logic [KEY_LEN_W-1:0]   pos_inc;
    logic [KEY_TOTAL_BYTES-1:0][BYTE_W-1:0] key_bytes;
    logic [BYTE_W-1:0]      key_add;
    logic [BYTE_W-1:0]      ram_q;
    logic [BYTE_W-1:0]      sval;
    logic [SBOX_ADDR_W-1:0] addr_a;
    logic [SBOX_ADDR_W-1:0] j_sum;
    logic [SBOX_ADDR_W-1:0] t_addr;
    logic                   ram_re, ram_we;
    logic [SBOX_ADDR_W-1:0] ram_raddr, ram_waddr;
    logic [BYTE_W-1:0]      ram_wdata;

    // A zero length runs as one byte; longer lengths saturate.
    always_comb begin
        if (key_length == '0) begin
            len_eff = KEY_LEN_W'(1);
        end else if (key_length > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = key_length;
        end
    end

    assign key_bytes = {key_high, key_low};
    assign pos_inc   = KEY_LEN_W'(pos_reg) + KEY_LEN_W'(1);
    assign key_add   = cmd.key_mode ? key_bytes[KEY_SEL_W'(pos_reg)] : '0;

    // Entries never written since the last clear hold their own address.
    assign sval   = rd_valid_reg ? ram_q : rd_addr_reg;
    assign addr_a = cmd.key_mode ? k_reg : i_reg;
    assign j_sum  = j_reg + sval + key_add;
    assign t_addr = si_reg + sj_reg;

    always_comb begin
        ram_re    = cmd.rd_a || cmd.rd_b || cmd.rd_t;
        ram_raddr = t_addr;
        if (cmd.rd_a) begin
            ram_raddr = addr_a;
        end else if (cmd.rd_b) begin
            ram_raddr = j_sum;
        end
        ram_we    = cmd.wr_a || cmd.wr_b;
        ram_waddr = cmd.wr_a ? addr_a : j_reg;
        ram_wdata = cmd.wr_a ? sval : si_reg;
    end

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.accept_key) begin
            valid_reg <= '0;
        end else if (ram_we) begin
            valid_reg[ram_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            rd_valid_reg <= valid_reg[ram_raddr];
            rd_addr_reg  <= ram_raddr;
        end
        if (cmd.accept_data) begin
            data_reg <= data_byte;
        end
        if (cmd.rd_b) begin
            si_reg <= sval;
        end
        if (cmd.wr_a) begin
            sj_reg <= sval;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
            pos_reg <= '0;
        end else begin
            if (cmd.accept_key) begin
                j_reg   <= '0;
                k_reg   <= '0;
                pos_reg <= '0;
            end
            if (cmd.accept_data) begin
                i_reg <= i_reg + SBOX_ADDR_W'(1);
            end
            if (cmd.rd_b) begin
                j_reg <= j_sum;
            end
            if (cmd.wr_b && cmd.key_mode) begin
                k_reg   <= k_reg + SBOX_ADDR_W'(1);
                pos_reg <= (pos_inc >= len_eff) ? '0 : POS_W'(pos_inc);
                if (sts.last_step) begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= data_reg ^ sval;
        end
    end

    assign sts.last_step = (k_reg == '1);
    assign sts.out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

endmodule
`default_nettype wire

// ===== dv/rc4_stream_cipher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher checker
// Watches the configuration port and both stream channels, keeps its own
// copy of the S-box state, and checks every output byte against the
// keystream it expects.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [rc4_pkg::BYTE_W-1:0]      s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [rc4_pkg::BYTE_W-1:0]      m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                   fail_count,
    output int                                   pending
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0]     sbox_perm [SBOX_DEPTH];
    logic [BYTE_W-1:0]     idx_i;
    logic [BYTE_W-1:0]     idx_j;
    logic [KEY_LEN_W-1:0]  key_len_q;
    logic [KEY_REG_W-1:0]  key_low_q;
    logic [KEY_REG_W-1:0]  key_high_q;
    logic [BYTE_W-1:0]     expected_out_bytes [$];
    int                    n_fail = 0;

    task automatic report_mismatch(input string what);
        $display("checker: %s (at %0t)", what, $time);
        n_fail++;
    endtask

    // Key scheduling: identity, then 256 swap steps driven by the key bytes.
    task automatic rekey_sbox();
        int                len_eff;
        int                pos;
        logic [BYTE_W-1:0] jj;
        logic [BYTE_W-1:0] kb;
        logic [BYTE_W-1:0] tmp;
        len_eff = int'(key_len_q);
        if (len_eff == 0) len_eff = 1;
        if (len_eff > KEY_TOTAL_BYTES) len_eff = KEY_TOTAL_BYTES;
        for (int k = 0; k < SBOX_DEPTH; k++) sbox_perm[k] = BYTE_W'(k);
        jj  = '0;
        pos = 0;
        for (int k = 0; k < SBOX_DEPTH; k++) begin
            kb = (pos < 8) ? key_low_q[pos*8 +: 8] : key_high_q[(pos-8)*8 +: 8];
            jj = jj + sbox_perm[k] + kb;
            tmp          = sbox_perm[k];
            sbox_perm[k] = sbox_perm[jj];
            sbox_perm[jj] = tmp;
            pos = (pos + 1 >= len_eff) ? 0 : pos + 1;
        end
        idx_i = '0;
        idx_j = '0;
    endtask

    // One keystream step: advance the indices, swap, XOR the next byte in.
    task automatic keystream_xor(input logic [BYTE_W-1:0] din,
                                 output logic [BYTE_W-1:0] dout);
        logic [BYTE_W-1:0] tmp;
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox_perm[idx_i];
        tmp              = sbox_perm[idx_i];
        sbox_perm[idx_i] = sbox_perm[idx_j];
        sbox_perm[idx_j] = tmp;
        dout = din ^ sbox_perm[BYTE_W'(sbox_perm[idx_i] + sbox_perm[idx_j])];
    endtask

    always @(posedge aclk) begin
        logic [BYTE_W-1:0] want;
        logic [BYTE_W-1:0] got_byte;
        if (!aresetn) begin
            for (int k = 0; k < SBOX_DEPTH; k++) sbox_perm[k] = BYTE_W'(k);
            idx_i      = '0;
            idx_j      = '0;
            key_len_q  = KEY_LEN_RESET;
            key_low_q  = '0;
            key_high_q = '0;
            expected_out_bytes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_KEY_LENGTH: key_len_q  = cfg_data[KEY_LEN_W-1:0];
                    REG_KEY_LOW:    key_low_q  = cfg_data;
                    REG_KEY_HIGH:   key_high_q = cfg_data;
                    default: ;
                endcase
            end
            // Results first: a byte leaving now belongs to an earlier input.
            if (m_tvalid && m_tready) begin
                got_byte = m_tdata;
                if (expected_out_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected out_byte 0x%02h", got_byte));
                end else begin
                    want = expected_out_bytes.pop_front();
                    if (got_byte !== want)
                        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                                  got_byte, want));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_REKEY) begin
                    rekey_sbox();
                end else begin
                    keystream_xor(s_tdata, want);
                    expected_out_bytes = {expected_out_bytes, want};
                end
            end
        end
        pending    <= expected_out_bytes.size();
        fail_count <= n_fail;
    end

endmodule

// ===== dv/rc4_stream_cipher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives rekey and data transactions through the stream input under several
// key settings, stalls the result side on its own pattern, and leaves all
// prediction and comparison to the checker instance.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;
    import rc4_pkg::*;

    // The address space has one slot that maps to no register; writes there
    // must be dropped by the block.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // A rekey transaction keeps the block busy for a full key schedule without
    // producing a result, so every settle waits a bit longer than that.
    localparam int REKEY_CYCLES  = 1100;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 96;
    localparam int NUM_PHASES    = 5;

    logic                   aclk;
    logic                   aresetn      = 1'b0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata      = '0;
    logic                   s_tuser      = OP_DATA;
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [BYTE_W-1:0]      m_tdata;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   hold_request = 1'b0;
    int                     fail_count;
    int                     pending;

    rc4_stream_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] data_byte
        .s_tuser   (s_tuser),     // [0] opcode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] out_byte
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    rc4_stream_cipher_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest legal run of this stimulus.
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one transaction and hold it until the block takes it. Every call
    // starts right after a rising edge, and the caller returns at the edge of
    // acceptance with tvalid still high, so back-to-back items never lower
    // and raise tvalid within one time step.
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] data_byte);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data_byte;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Writes one register and leaves the write enable high; the caller lowers
    // it once the sequence of writes is over.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    // Full key setup. The upper bits of the length word are random so that
    // the block is seen to ignore them, and a stray write to the unmapped
    // index goes along with every setup.
    task automatic load_key(input logic [KEY_LEN_W-1:0] len,
                            input logic [KEY_REG_W-1:0] lo,
                            input logic [KEY_REG_W-1:0] hi);
        write_reg(REG_KEY_LENGTH,
                  ({$urandom, $urandom} << KEY_LEN_W) | CFG_DATA_W'(len));
        write_reg(REG_UNUSED, {$urandom, $urandom});
        write_reg(REG_KEY_LOW, lo);
        write_reg(REG_KEY_HIGH, hi);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Brings the block to idle: input quiet, every expected byte received,
    // then enough cycles for a trailing rekey to finish its schedule.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (REKEY_CYCLES) @(posedge aclk);
    endtask

    // Result side. The ready pattern rotates through fully open, coin-flip,
    // mostly open and a fixed one-in-five stall, so stalls land on every step
    // of the block's schedule. Once asked, it closes for a long stretch while
    // the sender keeps offering, which fills the result register and must back
    // up the input channel.
    initial begin
        int  cycle_cnt;
        int  hold_cnt;
        bit  hold_done;
        cycle_cnt = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(posedge aclk);
                    hold_cnt++;
                end
                hold_done = 1'b1;
            end else begin
                case ((cycle_cnt / 300) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ((cycle_cnt % 5) != 0);
                endcase
            end
        end
    end

    // Stimulus.
    initial begin
        int                     lengths [NUM_PHASES];
        logic [KEY_REG_W-1:0]   lo;
        logic [KEY_REG_W-1:0]   hi;
        int                     burst_left;
        int                     gap;
        int                     gap_max;
        int                     drain_cnt;
        logic                   op;

        lengths = '{16, 1, 0, 31, 7};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Data before any rekey runs on the identity S-box left
        // by reset; then the reset key (all zeros, length 16) is scheduled.
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'hA5);
        send_item(OP_REKEY, 8'hFF);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        settle();

        // A zero key length must behave as a single key byte.
        load_key(5'd0, '1, {$urandom, $urandom});
        send_item(OP_REKEY, 8'h00);
        send_item(OP_DATA, 8'h5A);
        send_item(OP_DATA, 8'hFF);
        settle();

        // The largest length word saturates to the full sixteen bytes.
        load_key(5'd31, {$urandom, $urandom}, '1);
        send_item(OP_REKEY, 8'h3C);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hC3);
        settle();

        // Shortest legal key, and two rekeys back to back, which must leave
        // the same state as one.
        load_key(5'd1, 64'h0000_0000_0000_00FF, '0);
        send_item(OP_REKEY, 8'h00);
        send_item(OP_DATA, 8'h01);
        send_item(OP_REKEY, 8'h80);
        send_item(OP_REKEY, 8'h7F);
        send_item(OP_DATA, 8'hFE);
        send_item(OP_DATA, 8'h80);
        settle();

        // Random part: one key setting per phase, mostly data bytes with an
        // occasional rekey so each phase walks a long keystream from several
        // fresh schedules. Phase 0 has a sender with no gaps at all.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 3)
                0:       begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
                1:       begin lo = '1; hi = '1; end
                default: begin lo = {$urandom, $urandom}; hi = '0; end
            endcase
            load_key(KEY_LEN_W'(lengths[ph]), lo, hi);
            send_item(OP_REKEY, BYTE_W'($urandom_range(0, 255)));
            gap_max    = ph * 2;
            burst_left = $urandom_range(1, 16);
            for (int n = 1; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    gap = (gap_max == 0 || $urandom_range(0, 2) == 0)
                          ? 0 : $urandom_range(1, gap_max);
                    if (gap > 0) begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                op = ($urandom_range(0, 11) == 0) ? OP_REKEY : OP_DATA;
                // The long receiver hold starts after the first data byte of
                // phase 1, and the bytes around it stay data so that results
                // pile up instead of the hold passing during a key schedule.
                if (ph == 1 && n < 8) op = OP_DATA;
                send_item(op, BYTE_W'($urandom_range(0, 255)));
                if (ph == 1 && n == 1) hold_request <= 1'b1;
            end
            settle();
        end

        // Everything has been accepted; settle already waited out the tail of
        // a possible last rekey. Give stray results one more bounded window.
        drain_cnt = 0;
        while (pending != 0 && drain_cnt < 20000) begin
            @(posedge aclk);
            drain_cnt++;
        end
        repeat (20) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
